FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property holds at every clock edge out of reset
`define SLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition never holds at a clock edge out of reset
`define SLA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SLA_ASSERT(lbl, prop, msg)
`define SLA_NEVER(lbl, cond, msg)
`endif
`endif

FILE: design/sla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sla_pkg
// shared types and constants of the segment list allocator
// ----------------------------------------------------------------------------
package sla_pkg;

  localparam int MaxSegments = 64;
  localparam int IdxW        = $clog2(MaxSegments);
  localparam int CntW        = IdxW + 1;
  localparam int BlkW        = 16;
  localparam logic [BlkW-1:0] TotalReset = BlkW'(1024);

  // one table entry
  typedef struct packed {
    logic            used;
    logic [BlkW-1:0] start;
    logic [BlkW-1:0] size;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } command_e;

endpackage

FILE: design/segment_list_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_list_allocator_core
// first fit / next fit segment allocator over a sorted segment table in ram
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// command   in         start & !busy             command, req_size, fit_mode,
//                                                release_start, release_size
// result    out        result_valid_o (1 cycle)  result_start, status, used_blocks
// config    in         apb write, pready high    total_blocks at byte 0
//
// one transaction at a time; busy stays high until its result strobes.
// the table ram has one read port with registered read data, so each visited entry
// takes a read state and then a check or write state: allocate runs the next fit
// lookup (next fit mode only), the search, the shift up, then the remainder insert
// and the mark; release runs the lookup, the neighbor reads, the merge and the shift
// down; a zero request answers at once. reset and a total_blocks write rewrite entry 0.
// the receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
module segment_list_allocator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          command_i,
  input  logic [sla_pkg::BlkW-1:0]      req_size_i,
  input  logic                          fit_mode_i,
  input  logic [sla_pkg::BlkW-1:0]      release_start_i,
  input  logic [sla_pkg::BlkW-1:0]      release_size_i,
  // result channel
  output logic                          result_valid_o,
  output logic [sla_pkg::BlkW-1:0]      result_start_o,
  output logic [1:0]                    status_o,
  output logic [sla_pkg::BlkW-1:0]      used_blocks_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int IdxW = sla_pkg::IdxW;
  localparam int CntW = sla_pkg::CntW;
  localparam int BlkW = sla_pkg::BlkW;

  typedef enum logic [15:0] {
    S_INIT    = 16'h0001,
    S_IDLE    = 16'h0002,
    S_FIND_RD = 16'h0004,
    S_FIND_CK = 16'h0008,
    S_SRCH_RD = 16'h0010,
    S_SRCH_CK = 16'h0020,
    S_SHUP_RD = 16'h0040,
    S_SHUP_WR = 16'h0080,
    S_INS_WR  = 16'h0100,
    S_SET_WR  = 16'h0200,
    S_NB_RD   = 16'h0400,
    S_NB_CK   = 16'h0800,
    S_MRG_WR  = 16'h1000,
    S_SHDN_RD = 16'h2000,
    S_SHDN_WR = 16'h4000,
    S_FAIL    = 16'h8000
  } state_e;

  state_e state_q, state_d;

  // latched command
  logic            cmd_q, cmd_d;
  logic [BlkW-1:0] req_q, req_d;
  logic [BlkW-1:0] rstart_q, rstart_d;
  logic [BlkW-1:0] rsize_q, rsize_d;

  // allocator state
  logic [BlkW-1:0] total_q, total_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [BlkW-1:0] last_q, last_d;
  logic [BlkW-1:0] used_q, used_d;

  // walk state
  logic [IdxW-1:0] addr_q, addr_d;
  logic [CntW-1:0] k_q, k_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [BlkW-1:0] cur_start_q, cur_start_d;
  logic [BlkW-1:0] cur_size_q, cur_size_d;
  logic [IdxW-1:0] lo_q, lo_d;
  logic [IdxW-1:0] hi_q, hi_d;
  logic [BlkW-1:0] mrg_q, mrg_d;
  logic            nb_next_q, nb_next_d;
  logic [1:0]      rem_q, rem_d;

  // result registers
  logic            rv_q, rv_d;
  logic [BlkW-1:0] rs_q, rs_d;
  logic [1:0]      st_q, st_d;

  // ram port
  logic            we;
  logic [IdxW-1:0] waddr;
  sla_pkg::entry_t wdata, rdata;

  logic            cfg_wr;
  logic [CntW-1:0] k_inc, idx_inc;
  logic [BlkW-1:0] key, rest;

  sla_ram #(
    .Width (sla_pkg::EntryW),
    .Depth (sla_pkg::MaxSegments)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - BlkW){1'b0}}, total_q} : 32'd0;

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = rv_q;
  assign result_start_o = rs_q;
  assign status_o       = st_q;
  assign used_blocks_o  = used_q;

  assign k_inc   = k_q + CntW'(1);
  assign idx_inc = {1'b0, idx_q} + CntW'(1);
  assign key     = (cmd_q == sla_pkg::CMD_RELEASE) ? rstart_q : last_q;
  assign rest    = cur_size_q - req_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    req_d       = req_q;
    rstart_d    = rstart_q;
    rsize_d     = rsize_q;
    total_d     = total_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    used_d      = used_q;
    addr_d      = addr_q;
    k_d         = k_q;
    idx_d       = idx_q;
    cur_start_d = cur_start_q;
    cur_size_d  = cur_size_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mrg_d       = mrg_q;
    nb_next_d   = nb_next_q;
    rem_d       = rem_q;
    rv_d        = 1'b0;
    rs_d        = rs_q;
    st_d        = st_q;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = rdata;

    unique case (state_q)
      S_INIT: begin
        we          = 1'b1;
        waddr       = '0;
        wdata.used  = 1'b0;
        wdata.start = '0;
        wdata.size  = total_q;
        cnt_d       = CntW'(1);
        last_d      = '0;
        used_d      = '0;
        state_d     = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_d    = command_i;
          req_d    = req_size_i;
          rstart_d = release_start_i;
          rsize_d  = release_size_i;
          addr_d   = '0;
          k_d      = '0;
          priority if (command_i == sla_pkg::CMD_RELEASE) begin
            state_d = S_FIND_RD;
          end else if (req_size_i == '0) begin
            rv_d    = 1'b1;
            rs_d    = '0;
            st_d    = sla_pkg::ST_NOFIT;
          end else if (fit_mode_i == 1'b0) begin
            state_d = S_FIND_RD;
          end else begin
            state_d = S_SRCH_RD;
          end
        end
      end
      S_FIND_RD: state_d = S_FIND_CK;
      S_FIND_CK: begin
        if (rdata.start == key) begin
          idx_d = addr_q;
          if (cmd_q == sla_pkg::CMD_ALLOC) begin
            k_d     = '0;
            state_d = S_SRCH_RD;
          end else if (rdata.size != rsize_q) begin
            st_d    = sla_pkg::ST_NOTFOUND;
            state_d = S_FAIL;
          end else if (!rdata.used) begin
            st_d    = sla_pkg::ST_OK;
            state_d = S_FAIL;
          end else begin
            used_d      = used_q - rdata.size;
            lo_d        = addr_q;
            hi_d        = addr_q;
            mrg_d       = rdata.size;
            cur_start_d = rdata.start;
            if (addr_q != '0) begin
              addr_d    = addr_q - IdxW'(1);
              nb_next_d = 1'b0;
              state_d   = S_NB_RD;
            end else if ({1'b0, addr_q} + CntW'(1) < cnt_q) begin
              addr_d    = addr_q + IdxW'(1);
              nb_next_d = 1'b1;
              state_d   = S_NB_RD;
            end else begin
              state_d   = S_MRG_WR;
            end
          end
        end else if (k_inc == cnt_q) begin
          if (cmd_q == sla_pkg::CMD_ALLOC) begin
            // stale next fit start, search from the table head
            addr_d  = '0;
            k_d     = '0;
            state_d = S_SRCH_RD;
          end else begin
            st_d    = sla_pkg::ST_NOTFOUND;
            state_d = S_FAIL;
          end
        end else begin
          k_d     = k_inc;
          addr_d  = addr_q + IdxW'(1);
          state_d = S_FIND_RD;
        end
      end
      S_SRCH_RD: state_d = S_SRCH_CK;
      S_SRCH_CK: begin
        if (!rdata.used && rdata.size >= req_q) begin
          idx_d       = addr_q;
          cur_start_d = rdata.start;
          cur_size_d  = rdata.size;
          if (rdata.size == req_q) begin
            state_d = S_SET_WR;
          end else if (cnt_q == CntW'(sla_pkg::MaxSegments)) begin
            st_d    = sla_pkg::ST_FULL;
            state_d = S_FAIL;
          end else if (cnt_q > {1'b0, addr_q} + CntW'(1)) begin
            k_d     = cnt_q;
            addr_d  = IdxW'(cnt_q - CntW'(1));
            state_d = S_SHUP_RD;
          end else begin
            state_d = S_INS_WR;
          end
        end else if (k_inc == cnt_q) begin
          st_d    = sla_pkg::ST_NOFIT;
          state_d = S_FAIL;
        end else begin
          k_d     = k_inc;
          addr_d  = ({1'b0, addr_q} + CntW'(1) == cnt_q) ? '0 : addr_q + IdxW'(1);
          state_d = S_SRCH_RD;
        end
      end
      S_SHUP_RD: state_d = S_SHUP_WR;
      S_SHUP_WR: begin
        // move entry k-1 up to k
        we    = 1'b1;
        waddr = k_q[IdxW-1:0];
        wdata = rdata;
        k_d   = k_q - CntW'(1);
        if (k_q - CntW'(1) > idx_inc) begin
          addr_d  = IdxW'(k_q - CntW'(2));
          state_d = S_SHUP_RD;
        end else begin
          state_d = S_INS_WR;
        end
      end
      S_INS_WR: begin
        // free remainder after the split
        we          = 1'b1;
        waddr       = idx_inc[IdxW-1:0];
        wdata.used  = 1'b0;
        wdata.start = cur_start_q + req_q;
        wdata.size  = rest;
        cnt_d       = cnt_q + CntW'(1);
        state_d     = S_SET_WR;
      end
      S_SET_WR: begin
        we          = 1'b1;
        waddr       = idx_q;
        wdata.used  = 1'b1;
        wdata.start = cur_start_q;
        wdata.size  = req_q;
        last_d      = cur_start_q;
        used_d      = used_q + req_q;
        rv_d        = 1'b1;
        rs_d        = cur_start_q;
        st_d        = sla_pkg::ST_OK;
        state_d     = S_IDLE;
      end
      S_NB_RD: state_d = S_NB_CK;
      S_NB_CK: begin
        if (!nb_next_q) begin
          if (!rdata.used) begin
            lo_d        = addr_q;
            mrg_d       = mrg_q + rdata.size;
            cur_start_d = rdata.start;
          end
          if (idx_inc < cnt_q) begin
            addr_d    = idx_q + IdxW'(1);
            nb_next_d = 1'b1;
            state_d   = S_NB_RD;
          end else begin
            state_d   = S_MRG_WR;
          end
        end else begin
          if (!rdata.used) begin
            hi_d  = addr_q;
            mrg_d = mrg_q + rdata.size;
          end
          state_d = S_MRG_WR;
        end
      end
      S_MRG_WR: begin
        we          = 1'b1;
        waddr       = lo_q;
        wdata.used  = 1'b0;
        wdata.start = cur_start_q;
        wdata.size  = mrg_q;
        rem_d       = 2'(hi_q - lo_q);
        k_d         = {1'b0, hi_q} + CntW'(1);
        if (hi_q != lo_q && {1'b0, hi_q} + CntW'(1) < cnt_q) begin
          addr_d  = hi_q + IdxW'(1);
          state_d = S_SHDN_RD;
        end else begin
          cnt_d   = cnt_q - CntW'(hi_q - lo_q);
          rv_d    = 1'b1;
          rs_d    = '0;
          st_d    = sla_pkg::ST_OK;
          state_d = S_IDLE;
        end
      end
      S_SHDN_RD: state_d = S_SHDN_WR;
      S_SHDN_WR: begin
        // close the gap left by merged entries
        we    = 1'b1;
        waddr = IdxW'(k_q - CntW'(rem_q));
        wdata = rdata;
        k_d   = k_inc;
        if (k_inc < cnt_q) begin
          addr_d  = addr_q + IdxW'(1);
          state_d = S_SHDN_RD;
        end else begin
          cnt_d   = cnt_q - CntW'(rem_q);
          rv_d    = 1'b1;
          rs_d    = '0;
          st_d    = sla_pkg::ST_OK;
          state_d = S_IDLE;
        end
      end
      S_FAIL: begin
        rv_d    = 1'b1;
        rs_d    = '0;
        state_d = S_IDLE;
      end
      default: state_d = S_INIT;
    endcase

    // total_blocks write restarts the table
    if (cfg_wr) begin
      total_d = pwdata[BlkW-1:0];
      state_d = S_INIT;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      total_q <= sla_pkg::TotalReset;
      cnt_q   <= CntW'(1);
      last_q  <= '0;
      used_q  <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      used_q  <= used_d;
      rv_q    <= rv_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    req_q       <= req_d;
    rstart_q    <= rstart_d;
    rsize_q     <= rsize_d;
    addr_q      <= addr_d;
    k_q         <= k_d;
    idx_q       <= idx_d;
    cur_start_q <= cur_start_d;
    cur_size_q  <= cur_size_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mrg_q       <= mrg_d;
    nb_next_q   <= nb_next_d;
    rem_q       <= rem_d;
    rs_q        <= rs_d;
    st_q        <= st_d;
  end

  // checks
`include "assert_macros.svh"
  `SLA_ASSERT(a_cnt_range, cnt_q >= CntW'(1) && cnt_q <= CntW'(sla_pkg::MaxSegments), "bad count")
  `SLA_ASSERT(a_accept_moves, (start && !busy) |=> (busy || result_valid_o), "transaction lost")
  `SLA_NEVER(a_strobe_idle, result_valid_o && busy, "result strobe while busy")
  `SLA_NEVER(a_shift_above, (state_q == S_SHUP_WR) && (k_q <= idx_inc), "shift below split")

endmodule

FILE: design/sla_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sla_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module sla_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// random and directed allocate / release traffic against a table predictor,
// with total_blocks changed between phases over the apb port
// ----------------------------------------------------------------------------

// predictor of the segment table and checker of result transactions
class alloc_scoreboard;
  localparam int Segs = sla_pkg::MaxSegments;

  bit [15:0] tbl_start[Segs];
  bit [15:0] tbl_size[Segs];
  bit        tbl_used[Segs];
  int        tbl_count;
  bit [15:0] last_start;
  bit [15:0] used_total;
  bit [15:0] capacity;

  bit [15:0] pend_start[$];
  bit [1:0]  pend_status[$];
  bit [15:0] pend_used[$];
  int        errors;

  function void clear_table(bit [15:0] blocks);
    capacity     = blocks;
    tbl_start[0] = '0;
    tbl_size[0]  = blocks;
    tbl_used[0]  = 1'b0;
    tbl_count    = 1;
    last_start   = '0;
    used_total   = '0;
  endfunction

  function int find_seg(bit [15:0] s);
    for (int i = 0; i < tbl_count; i++) if (tbl_start[i] == s) return i;
    return -1;
  endfunction

  // allocate: next fit or first fit, split with a free remainder
  function sla_pkg::status_e allocate(bit [15:0] req, bit first_fit, output bit [15:0] got);
    int from, idx, hit;
    bit [15:0] rest;
    got = '0;
    if (req == 0) return sla_pkg::ST_NOFIT;
    from = 0;
    if (!first_fit) begin
      from = find_seg(last_start);
      if (from < 0) from = 0;
    end
    idx = from;
    hit = 0;
    for (int k = 0; k < tbl_count; k++) begin
      if (!tbl_used[idx] && tbl_size[idx] >= req) begin
        hit = 1;
        break;
      end
      idx = (idx + 1 >= tbl_count) ? 0 : idx + 1;
    end
    if (!hit) return sla_pkg::ST_NOFIT;
    rest = tbl_size[idx] - req;
    if (rest != 0) begin
      if (tbl_count >= Segs) return sla_pkg::ST_FULL;
      for (int k = tbl_count; k > idx + 1; k--) begin
        tbl_start[k] = tbl_start[k-1];
        tbl_size[k]  = tbl_size[k-1];
        tbl_used[k]  = tbl_used[k-1];
      end
      tbl_start[idx+1] = tbl_start[idx] + req;
      tbl_size[idx+1]  = rest;
      tbl_used[idx+1]  = 1'b0;
      tbl_count++;
    end
    tbl_size[idx] = req;
    tbl_used[idx] = 1'b1;
    last_start    = tbl_start[idx];
    used_total    = used_total + req;
    got           = tbl_start[idx];
    return sla_pkg::ST_OK;
  endfunction

  // release: free a used segment and merge with free neighbors
  function sla_pkg::status_e release_seg(bit [15:0] s, bit [15:0] sz);
    int i, lo, hi, gone;
    bit [15:0] merged;
    i = find_seg(s);
    if (i < 0 || tbl_size[i] != sz) return sla_pkg::ST_NOTFOUND;
    if (!tbl_used[i]) return sla_pkg::ST_OK;
    used_total = used_total - tbl_size[i];
    lo = (i > 0 && !tbl_used[i-1]) ? i - 1 : i;
    hi = (i + 1 < tbl_count && !tbl_used[i+1]) ? i + 1 : i;
    merged = '0;
    for (int k = lo; k <= hi; k++) merged += tbl_size[k];
    tbl_size[lo] = merged;
    tbl_used[lo] = 1'b0;
    gone = hi - lo;
    if (gone != 0) begin
      for (int k = hi + 1; k < tbl_count; k++) begin
        tbl_start[k-gone] = tbl_start[k];
        tbl_size[k-gone]  = tbl_size[k];
        tbl_used[k-gone]  = tbl_used[k];
      end
      tbl_count -= gone;
    end
    return sla_pkg::ST_OK;
  endfunction

  // note an accepted command transaction
  function void note_command(bit cmd, bit [15:0] req, bit mode, bit [15:0] rs, bit [15:0] rz);
    sla_pkg::status_e st;
    bit [15:0] got;
    got = '0;
    if (cmd == sla_pkg::CMD_ALLOC) st = allocate(req, mode, got);
    else st = release_seg(rs, rz);
    pend_start.insert(pend_start.size(), got);
    pend_status.insert(pend_status.size(), st);
    pend_used.insert(pend_used.size(), used_total);
  endfunction

  // check a result transaction against the oldest expectation
  function void check_result(bit [15:0] rstart, bit [1:0] st, bit [15:0] used);
    if (pend_start.size() == 0) begin
      $error("result with no command outstanding");
      errors++;
      return;
    end
    if (pend_start[0] != rstart) begin
      $error("result_start expected %0d actual %0d", pend_start[0], rstart);
      errors++;
    end
    if (pend_status[0] != st) begin
      $error("status expected %0d actual %0d", pend_status[0], st);
      errors++;
    end
    if (pend_used[0] != used) begin
      $error("used_blocks expected %0d actual %0d", pend_used[0], used);
      errors++;
    end
    void'(pend_start.pop_front());
    void'(pend_status.pop_front());
    void'(pend_used.pop_front());
  endfunction

  // pick a used segment, or -1
  function int pick_used();
    int cand[$];
    for (int i = 0; i < tbl_count; i++) if (tbl_used[i]) cand.insert(cand.size(), i);
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(cand.size() - 1)];
  endfunction
endclass

module testbench;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        command_i;
  logic [15:0] req_size_i;
  logic        fit_mode_i;
  logic [15:0] release_start_i;
  logic [15:0] release_size_i;
  logic        result_valid_o;
  logic [15:0] result_start_o;
  logic [1:0]  status_o;
  logic [15:0] used_blocks_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  alloc_scoreboard alloc_sb;

  segment_list_allocator_core u_top (.*);

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      alloc_sb.check_result(result_start_o, status_o, used_blocks_o);
  end

  // run limit
  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

  // write total_blocks over apb while idle
  task automatic write_total(bit [15:0] blocks);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= '0;
    pwdata  <= {16'($urandom_range(65535)), blocks};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    alloc_sb.clear_table(blocks);
    @(posedge clk_i);
  endtask

  // send one command transaction after a random gap
  task automatic send_command(bit cmd, bit [15:0] req, bit mode, bit [15:0] rs, bit [15:0] rz);
    int gap;
    gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(9);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1'b1;
    command_i       <= cmd;
    req_size_i      <= req;
    fit_mode_i      <= mode;
    release_start_i <= rs;
    release_size_i  <= rz;
    do @(posedge clk_i); while (busy);
    alloc_sb.note_command(cmd, req, mode, rs, rz);
  endtask

  // wait until every expected result has arrived, then settle
  task automatic drain();
    start <= 1'b0;
    while (alloc_sb.pend_start.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // random allocate-heavy traffic with releases of real segments
  task automatic random_phase(int count, int max_req);
    int idx;
    for (int n = 0; n < count; n++) begin
      idx = alloc_sb.pick_used();
      case ($urandom_range(9))
        0, 1, 2, 3: send_command(sla_pkg::CMD_ALLOC, 16'($urandom_range(max_req, 1)),
                                 1'($urandom_range(1)), 16'($urandom), 16'($urandom));
        4, 5, 6, 7: begin
          if (idx >= 0)
            send_command(sla_pkg::CMD_RELEASE, 16'($urandom), 1'($urandom_range(1)),
                         alloc_sb.tbl_start[idx], alloc_sb.tbl_size[idx]);
          else
            send_command(sla_pkg::CMD_ALLOC, 16'($urandom_range(max_req, 1)),
                         1'($urandom_range(1)), 16'($urandom), 16'($urandom));
        end
        8: send_command(sla_pkg::CMD_ALLOC, 16'($urandom), 1'($urandom_range(1)),
                        16'($urandom), 16'($urandom));
        default: send_command(sla_pkg::CMD_RELEASE, 16'($urandom), 1'($urandom_range(1)),
                              16'($urandom), 16'($urandom));
      endcase
    end
  endtask

  initial begin
    alloc_sb = new();
    alloc_sb.clear_table(sla_pkg::TotalReset);
    rst_ni          = 1'b0;
    start           = 1'b0;
    command_i       = 1'b0;
    req_size_i      = '0;
    fit_mode_i      = 1'b0;
    release_start_i = '0;
    release_size_i  = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed: reset table
    send_command(sla_pkg::CMD_ALLOC, 16'd0, 1'b1, 16'd0, 16'd0);        // zero request
    send_command(sla_pkg::CMD_ALLOC, 16'd100, 1'b0, 16'd0, 16'd0);
    send_command(sla_pkg::CMD_ALLOC, 16'd200, 1'b1, 16'd0, 16'd0);
    send_command(sla_pkg::CMD_ALLOC, 16'hFFFF, 1'b1, 16'd0, 16'd0);     // no fit
    send_command(sla_pkg::CMD_RELEASE, 16'd0, 1'b0, 16'd100, 16'd7);    // size mismatch
    send_command(sla_pkg::CMD_RELEASE, 16'd0, 1'b0, 16'd555, 16'd1);    // start not found
    send_command(sla_pkg::CMD_RELEASE, 16'd0, 1'b0, 16'd0, 16'd100);    // first, next free? no
    send_command(sla_pkg::CMD_RELEASE, 16'd0, 1'b0, 16'd0, 16'd100);    // already free
    send_command(sla_pkg::CMD_ALLOC, 16'd50, 1'b0, 16'd0, 16'd0);       // next fit from the last allocation
    send_command(sla_pkg::CMD_RELEASE, 16'd0, 1'b1, 16'd100, 16'd200);  // merge with the free segment below
    send_command(sla_pkg::CMD_ALLOC, 16'd1024, 1'b1, 16'd0, 16'd0);
    drain();

    // zero capacity
    write_total(16'd0);
    send_command(sla_pkg::CMD_ALLOC, 16'd1, 1'b1, 16'hFFFF, 16'hFFFF);
    send_command(sla_pkg::CMD_RELEASE, 16'hFFFF, 1'b0, 16'd0, 16'd0);
    drain();

    // full capacity, exact fit, table full with single-block allocations
    write_total(16'hFFFF);
    send_command(sla_pkg::CMD_ALLOC, 16'hFFFF, 1'b0, 16'd0, 16'd0);
    send_command(sla_pkg::CMD_RELEASE, 16'd0, 1'b0, 16'd0, 16'hFFFF);
    for (int i = 0; i < 65; i++) send_command(sla_pkg::CMD_ALLOC, 16'd1, 1'b1, 16'd0, 16'd0);
    random_phase(150, 4);
    drain();

    write_total(16'd1);
    random_phase(30, 2);
    drain();

    write_total(16'd300);
    random_phase(400, 40);
    drain();

    write_total(16'hFFFF);
    random_phase(400, 4000);
    drain();

    if (alloc_sb.errors == 0 && alloc_sb.pend_start.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

FILE: segment_list_allocator_core.f
+incdir+design
design/sla_pkg.sv
design/sla_ram.sv
design/segment_list_allocator_core.sv
test/testbench.sv
